// ===== design/kal_pkg.sv =====
package kal_pkg;

  localparam int unsigned KeyWidth = 5;
  localparam int unsigned KeyCount = 5;
  localparam int unsigned TickWidth = 16;
  localparam int unsigned IdxWidth = 3;
  localparam int unsigned CodeWidth = 3;
  localparam int unsigned CfgIdxWidth = 3;

  localparam logic [KeyWidth-1:0] KeyMask =
    (KeyCount >= KeyWidth) ? {KeyWidth{1'b1}} : KeyWidth'((1 << KeyCount) - 1);

  localparam logic [TickWidth-1:0] RepeatStartReset = 16'd25;
  localparam logic [TickWidth-1:0] RepeatIntervalReset = 16'd2;
  localparam logic [TickWidth-1:0] LongPressReset = 16'd50;
  localparam logic [IdxWidth-1:0] UpKeyReset = 3'd1;
  localparam logic [IdxWidth-1:0] DownKeyReset = 3'd2;
  localparam logic [IdxWidth-1:0] BackKeyReset = 3'd3;
  localparam logic [IdxWidth-1:0] PowerKeyReset = 3'd0;

  // power key counts as already held out of reset
  localparam logic [KeyWidth-1:0] PrevDownReset =
    KeyWidth'(1 << PowerKeyReset) & KeyMask;

  localparam logic [CodeWidth-1:0] EvReset = 3'd5;
  localparam logic [CodeWidth-1:0] EvPowerOff = 3'd6;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgRepeatStart    = 3'd0,
    CfgRepeatInterval = 3'd1,
    CfgLongPress      = 3'd2,
    CfgUpKey          = 3'd3,
    CfgDownKey        = 3'd4,
    CfgBackKey        = 3'd5,
    CfgPowerKey       = 3'd6
  } kal_cfg_idx_e;

  typedef struct packed {
    logic [TickWidth-1:0] repeat_start;
    logic [TickWidth-1:0] repeat_interval;
    logic [TickWidth-1:0] long_press;
    logic [IdxWidth-1:0]  up_key;
    logic [IdxWidth-1:0]  down_key;
    logic [IdxWidth-1:0]  back_key;
    logic [IdxWidth-1:0]  power_key;
  } kal_cfg_t;

  typedef struct packed {
    logic                 valid;
    logic [CodeWidth-1:0] code;
  } kal_event_t;

endpackage

// ===== design/kal_cfg.sv =====
module kal_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kal_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [kal_pkg::TickWidth-1:0] cfg_wdata_i,
  output kal_pkg::kal_cfg_t             cfg_o
);

  kal_pkg::kal_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (kal_pkg::kal_cfg_idx_e'(cfg_index_i))
        kal_pkg::CfgRepeatStart:    cfg_d.repeat_start = cfg_wdata_i;
        kal_pkg::CfgRepeatInterval: cfg_d.repeat_interval = cfg_wdata_i;
        kal_pkg::CfgLongPress:      cfg_d.long_press = cfg_wdata_i;
        kal_pkg::CfgUpKey:          cfg_d.up_key = cfg_wdata_i[kal_pkg::IdxWidth-1:0];
        kal_pkg::CfgDownKey:        cfg_d.down_key = cfg_wdata_i[kal_pkg::IdxWidth-1:0];
        kal_pkg::CfgBackKey:        cfg_d.back_key = cfg_wdata_i[kal_pkg::IdxWidth-1:0];
        kal_pkg::CfgPowerKey:       cfg_d.power_key = cfg_wdata_i[kal_pkg::IdxWidth-1:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_start    <= kal_pkg::RepeatStartReset;
      cfg_q.repeat_interval <= kal_pkg::RepeatIntervalReset;
      cfg_q.long_press      <= kal_pkg::LongPressReset;
      cfg_q.up_key          <= kal_pkg::UpKeyReset;
      cfg_q.down_key        <= kal_pkg::DownKeyReset;
      cfg_q.back_key        <= kal_pkg::BackKeyReset;
      cfg_q.power_key       <= kal_pkg::PowerKeyReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/kal_core.sv =====
module kal_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  logic [kal_pkg::KeyWidth-1:0] key_down_i,
  input  kal_pkg::kal_cfg_t            cfg_i,
  output kal_pkg::kal_event_t          event_o
);

  localparam int unsigned KW = kal_pkg::KeyWidth;
  localparam int unsigned TW = kal_pkg::TickWidth;
  localparam int unsigned IW = kal_pkg::IdxWidth;

  logic [KW-1:0] prev_q, prev_d;
  logic          held_valid_q, held_valid_d;
  logic [IW-1:0] held_key_q, held_key_d;
  logic [TW-1:0] hold_q, hold_d;
  logic [TW-1:0] phase_q, phase_d;

  logic [KW-1:0] now, rise;
  logic          press_any, released, counted, rpt_on, is_rpt_key;
  logic [IW-1:0] press_key;
  logic          valid_a;
  logic [IW-1:0] key_a;
  logic [TW-1:0] hold_a, phase_a, hold_n, phase_inc;

  always_comb begin
    now       = key_down_i & kal_pkg::KeyMask;
    rise      = now & ~prev_q;
    press_any = |rise;
    press_key = '0;
    released  = 1'b0;
    for (int i = 0; i < KW; i++) begin
      if (rise[i]) press_key = IW'(i);
      if (held_key_q == IW'(i) && prev_q[i] && !now[i]) released = 1'b1;
    end

    valid_a = press_any | (held_valid_q & ~released);
    key_a   = press_any ? press_key : held_key_q;
    hold_a  = press_any ? '0 : hold_q;
    phase_a = press_any ? '0 : phase_q;

    counted    = (hold_a != {TW{1'b1}});
    hold_n     = hold_a + TW'(counted);
    rpt_on     = (hold_n >= cfg_i.repeat_start);
    phase_inc  = phase_a + TW'(1);
    is_rpt_key = (key_a == cfg_i.up_key) || (key_a == cfg_i.down_key);

    event_o.valid = press_any;
    event_o.code  = kal_pkg::CodeWidth'(press_key);

    prev_d       = now;
    held_valid_d = valid_a;
    held_key_d   = key_a;
    hold_d       = hold_a;
    phase_d      = phase_a;

    if (valid_a) begin
      hold_d = hold_n;
      if (rpt_on) begin
        if (phase_a == '0 && is_rpt_key) begin
          event_o.valid = 1'b1;
          event_o.code  = kal_pkg::CodeWidth'(key_a);
        end
        phase_d = (phase_inc >= cfg_i.repeat_interval) ? '0 : phase_inc;
      end
      if (counted && hold_n == cfg_i.long_press) begin
        if (key_a == cfg_i.back_key) begin
          event_o.valid = 1'b1;
          event_o.code  = kal_pkg::EvReset;
        end else if (key_a == cfg_i.power_key) begin
          event_o.valid = 1'b1;
          event_o.code  = kal_pkg::EvPowerOff;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= kal_pkg::PrevDownReset;
      held_valid_q <= 1'b0;
      held_key_q   <= '0;
      hold_q       <= '0;
      phase_q      <= '0;
    end else if (fire_i) begin
      prev_q       <= prev_d;
      held_valid_q <= held_valid_d;
      held_key_q   <= held_key_d;
      hold_q       <= hold_d;
      phase_q      <= phase_d;
    end
  end

  a_held_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid_q |-> (held_key_q < IW'(kal_pkg::KeyCount)))
    else $error("held key out of range");

  a_hold_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid_q |-> (hold_q != '0))
    else $error("held key with zero hold count");

endmodule

// ===== design/kal_out.sv =====
module kal_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [kal_pkg::CodeWidth-1:0] push_code_i,
  output logic                          space_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kal_pkg::CodeWidth-1:0] event_code_o
);

  logic                          main_valid_q, skid_valid_q;
  logic [kal_pkg::CodeWidth-1:0] main_code_q, skid_code_q;
  logic                          pop;

  assign pop     = main_valid_q & out_ready_i;
  assign space_o = ~skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      main_code_q <= skid_valid_q ? skid_code_q : push_code_i;
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_code_q <= push_code_i;
      end else begin
        main_code_q <= push_code_i;
      end
    end
  end

  assign out_valid_o  = main_valid_q;
  assign event_code_o = main_code_q;

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry without main entry");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("push into full result buffer");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (main_valid_q && !skid_valid_q))
    else $error("skid entry not moved up");

endmodule

// ===== design/keypad_autorepeat_longpress.sv =====
// Output: an accepted tick's event is registered in the result buffer before out_valid_o.
// Throughput: one tick per cycle; a two-entry result buffer keeps in_ready_o high
// while one event waits, so the input stalls only when both entries are full.
// Reset: asynchronous active low; config and state registers take their default values, the power
// key is seen as already held, and no key is tracked.
module keypad_autorepeat_longpress (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kal_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [kal_pkg::TickWidth-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [kal_pkg::KeyWidth-1:0]    key_down_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [kal_pkg::CodeWidth-1:0]   event_code_o
);

  kal_pkg::kal_cfg_t   cfg;
  kal_pkg::kal_event_t ev;
  logic                fire;

  assign fire = in_valid_i & in_ready_o;

  kal_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  kal_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .key_down_i (key_down_i),
    .cfg_i      (cfg),
    .event_o    (ev)
  );

  kal_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (fire & ev.valid),
    .push_code_i  (ev.code),
    .space_o      (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_code_o (event_code_o)
  );

endmodule
